/* src/tfr_pkg.sv */
// Shared types and constants for the texel format to RGBA8 expander.
// Holds the command word passed from the front end through the queue to the back end.
// No dependencies.
package tfr_pkg;

    // Source texel formats held in the format_mode register
    localparam logic [2:0] MODE_PAL4   = 3'd0;
    localparam logic [2:0] MODE_PAL8   = 3'd1;
    localparam logic [2:0] MODE_PASS16 = 3'd2;
    localparam logic [2:0] MODE_RGB    = 3'd3;
    localparam logic [2:0] MODE_GREY4  = 3'd4;
    localparam logic [2:0] MODE_GREY8  = 3'd5;

    // Configuration register indexes
    localparam logic REG_FORMAT_MODE = 1'b0;
    localparam logic REG_HAS_ALPHA   = 1'b1;

    localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

    typedef enum logic [2:0] {
        CMD_PALWR,
        CMD_PAL4,
        CMD_PAL8,
        CMD_PASS,
        CMD_RGB,
        CMD_GREY4,
        CMD_GREY8
    } cmd_kind_t;

    // color carries the palette entry, the gathered RGB triple, or the data byte in [7:0]
    typedef struct packed {
        cmd_kind_t   kind;
        logic [7:0]  idx;
        logic [23:0] color;
    } cmd_t;

endpackage

/* src/tfr_front.sv */
// Front end: accepts input beats, holds configuration and the RGB gather state.
// Turns every beat that needs work into a command for the queue. Uses tfr_pkg.
module tfr_front
    import tfr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [2:0]  cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        in_action,
    input  logic [7:0]  in_index,
    input  logic [7:0]  in_red,
    input  logic [7:0]  in_green,
    input  logic [7:0]  in_blue,
    input  logic [7:0]  in_data,
    input  logic        in_last,
    output logic        q_push,
    output cmd_t        q_cmd,
    input  logic        q_full
);

    logic [2:0]  mode_reg;
    logic        alpha_reg;
    logic [1:0]  phase_reg;
    logic [1:0]  phase_next;
    logic [15:0] held_reg;
    logic [15:0] held_next;
    logic        accept;

    assign in_ready = !q_full;
    assign accept   = in_valid && !q_full;

    always_comb
    begin
        phase_next = phase_reg;
        held_next  = held_reg;
        q_push     = 1'b0;
        q_cmd.kind  = CMD_PASS;
        q_cmd.idx   = in_index;
        q_cmd.color = {16'h0000, in_data};
        if (accept)
        begin
            if (!in_action)
            begin
                q_push      = 1'b1;
                q_cmd.kind  = CMD_PALWR;
                q_cmd.color = {in_red, in_green, in_blue};
            end
            else
            begin
                case (mode_reg)
                    MODE_PAL4:
                    begin
                        q_push     = 1'b1;
                        q_cmd.kind = CMD_PAL4;
                    end
                    MODE_PAL8:
                    begin
                        q_push     = 1'b1;
                        q_cmd.kind = CMD_PAL8;
                    end
                    MODE_PASS16:
                    begin
                        q_push     = 1'b1;
                        q_cmd.kind = CMD_PASS;
                    end
                    MODE_RGB:
                    begin
                        if (alpha_reg)
                        begin
                            q_push     = 1'b1;
                            q_cmd.kind = CMD_PASS;
                        end
                        else
                        begin
                            case (phase_reg)
                                2'd0:
                                begin
                                    held_next[7:0] = in_data;
                                    phase_next     = 2'd1;
                                end
                                2'd1:
                                begin
                                    held_next[15:8] = in_data;
                                    phase_next      = 2'd2;
                                end
                                default:
                                begin
                                    q_push      = 1'b1;
                                    q_cmd.kind  = CMD_RGB;
                                    q_cmd.color = {held_reg[7:0], held_reg[15:8], in_data};
                                    phase_next  = 2'd0;
                                end
                            endcase
                        end
                    end
                    MODE_GREY4:
                    begin
                        q_push     = 1'b1;
                        q_cmd.kind = CMD_GREY4;
                    end
                    MODE_GREY8:
                    begin
                        q_push     = 1'b1;
                        q_cmd.kind = CMD_GREY8;
                    end
                    default:
                    begin
                    end
                endcase
                // drop a partial RGB group at the end of a texture
                if (in_last)
                begin
                    phase_next = 2'd0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_PAL4;
            alpha_reg <= 1'b0;
            phase_reg <= 2'd0;
            held_reg  <= 16'h0000;
        end
        else
        begin
            if (cfg_we && cfg_index == REG_FORMAT_MODE)
            begin
                mode_reg <= cfg_data;
            end
            if (cfg_we && cfg_index == REG_HAS_ALPHA)
            begin
                alpha_reg <= cfg_data[0];
            end
            phase_reg <= phase_next;
            held_reg  <= held_next;
        end
    end

endmodule

/* src/tfr_queue.sv */
// Two-entry command queue between the front and back ends.
// Uses the command type from tfr_pkg.
module tfr_queue
    import tfr_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    input  logic pop,
    output cmd_t head_cmd,
    output logic full,
    output logic empty
);

    cmd_t       slot_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic [1:0] count_next;

    assign full     = count_reg == 2'd2;
    assign empty    = count_reg == 2'd0;
    assign head_cmd = slot_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        case ({push, pop})
            2'b10:   count_next = count_reg + 2'd1;
            2'b01:   count_next = count_reg - 2'd1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            count_reg <= count_next;
        end
    end

endmodule

/* src/tfr_back.sv */
// Back end: owns the palette memory, applies palette writes in order and
// expands each command into output bytes, one per cycle while the output is not stalled. Uses tfr_pkg.
module tfr_back
    import tfr_pkg::*;
#(
    parameter int PALETTE_ENTRIES = 256
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  cmd_t       q_cmd,
    input  logic       q_empty,
    output logic       q_pop,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_byte,
    output logic       out_last
);

    localparam int AW = $clog2(PALETTE_ENTRIES);
    localparam logic [8:0] PAL_LIMIT = 9'(PALETTE_ENTRIES);

    logic [23:0] palette_mem [PALETTE_ENTRIES];

    logic        cur_valid_reg;
    logic        cur_valid_next;
    cmd_t        cur_reg;
    cmd_t        cur_next;
    logic [2:0]  step_reg;
    logic [2:0]  step_next;
    logic [23:0] rdata_reg;
    logic        rd_oor_reg;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic [7:0]  out_byte_reg;
    logic [7:0]  out_byte_next;
    logic        out_last_reg;
    logic        out_last_next;

    logic        out_free;
    logic        advance;
    logic        at_last;
    logic        wr_en;
    logic        rd_en;
    logic [7:0]  rd_idx;
    logic [23:0] color;
    logic [7:0]  grey;

    function automatic logic [2:0] last_step(input cmd_kind_t kind);
        logic [2:0] n;
        case (kind)
            CMD_PAL4, CMD_GREY4:          n = 3'd7;
            CMD_PAL8, CMD_RGB, CMD_GREY8: n = 3'd3;
            default:                      n = 3'd0;
        endcase
        return n;
    endfunction

    assign out_free = !out_valid_reg || out_ready;
    assign advance  = cur_valid_reg && out_free;
    assign at_last  = step_reg == last_step(cur_reg.kind);
    assign q_pop    = !q_empty && (!cur_valid_reg || (advance && at_last));

    assign wr_en = q_pop && q_cmd.kind == CMD_PALWR && {1'b0, q_cmd.idx} < PAL_LIMIT;

    // Issue each lookup as its command is popped, and the second pal4 lookup on the first texel's alpha byte
    always_comb
    begin
        rd_en  = 1'b0;
        rd_idx = q_cmd.color[7:0];
        if (q_pop && q_cmd.kind == CMD_PAL4)
        begin
            rd_en  = 1'b1;
            rd_idx = {4'h0, q_cmd.color[7:4]};
        end
        else if (q_pop && q_cmd.kind == CMD_PAL8)
        begin
            rd_en  = 1'b1;
            rd_idx = q_cmd.color[7:0];
        end
        else if (advance && cur_reg.kind == CMD_PAL4 && step_reg == 3'd3)
        begin
            rd_en  = 1'b1;
            rd_idx = {4'h0, cur_reg.color[3:0]};
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            palette_mem[q_cmd.idx[AW-1:0]] <= q_cmd.color;
        end
        if (rd_en)
        begin
            rdata_reg  <= palette_mem[rd_idx[AW-1:0]];
            rd_oor_reg <= !({1'b0, rd_idx} < PAL_LIMIT);
        end
    end

    always_comb
    begin
        grey = step_reg[2] ? {cur_reg.color[3:0], 4'h0} : {cur_reg.color[7:4], 4'h0};
        case (cur_reg.kind)
            CMD_PAL4, CMD_PAL8: color = rd_oor_reg ? 24'h000000 : rdata_reg;
            CMD_GREY4:          color = {grey, grey, grey};
            CMD_GREY8:          color = {3{cur_reg.color[7:0]}};
            default:            color = cur_reg.color;
        endcase
    end

    always_comb
    begin
        cur_valid_next = cur_valid_reg;
        cur_next       = cur_reg;
        step_next      = step_reg;
        out_valid_next = out_valid_reg;
        out_byte_next  = out_byte_reg;
        out_last_next  = out_last_reg;

        if (advance)
        begin
            out_valid_next = 1'b1;
            out_last_next  = at_last;
            if (cur_reg.kind == CMD_PASS)
            begin
                out_byte_next = cur_reg.color[7:0];
            end
            else
            begin
                case (step_reg[1:0])
                    2'd0:    out_byte_next = color[23:16];
                    2'd1:    out_byte_next = color[15:8];
                    2'd2:    out_byte_next = color[7:0];
                    default: out_byte_next = ALPHA_OPAQUE;
                endcase
            end
            step_next = step_reg + 3'd1;
            if (at_last)
            begin
                cur_valid_next = 1'b0;
            end
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end

        if (q_pop)
        begin
            cur_valid_next = q_cmd.kind != CMD_PALWR;
            cur_next       = q_cmd;
            step_next      = 3'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            step_reg      <= 3'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cur_valid_reg <= cur_valid_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg      <= cur_next;
        out_byte_reg <= out_byte_next;
        out_last_reg <= out_last_next;
    end

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign out_last  = out_last_reg;

endmodule

/* src/texel_format_to_rgba8.sv */
// Texel format to RGBA8 expander. Output: one byte per cycle while m_tready holds;
// a data beat yields 8 bytes in the 4-bit modes, 4 in pal8, grey8 and gathered RGB,
// 1 in passthrough; a palette write yields none. The output byte stream sets the
// rate. Asynchronous active-low reset clears control state and the RGB gather;
// palette contents are undefined until written.
module texel_format_to_rgba8
    import tfr_pkg::*;
#(
    parameter int PALETTE_ENTRIES = 256
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [2:0]  cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // pal_index, pal_red, pal_green, pal_blue, data_byte
    input  logic        s_tuser,   // action
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // out_byte
    output logic        m_tlast
);

    cmd_t push_cmd;
    cmd_t head_cmd;
    logic q_push;
    logic q_pop;
    logic q_full;
    logic q_empty;

    tfr_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_action (s_tuser),
        .in_index  (s_tdata[7:0]),
        .in_red    (s_tdata[15:8]),
        .in_green  (s_tdata[23:16]),
        .in_blue   (s_tdata[31:24]),
        .in_data   (s_tdata[39:32]),
        .in_last   (s_tlast),
        .q_push    (q_push),
        .q_cmd     (push_cmd),
        .q_full    (q_full)
    );

    tfr_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_cmd (push_cmd),
        .pop      (q_pop),
        .head_cmd (head_cmd),
        .full     (q_full),
        .empty    (q_empty)
    );

    tfr_back #(
        .PALETTE_ENTRIES (PALETTE_ENTRIES)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_cmd     (head_cmd),
        .q_empty   (q_empty),
        .q_pop     (q_pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_byte  (m_tdata),
        .out_last  (m_tlast)
    );

endmodule

/* src/tfr_checker.sv */
// Port-level checks for texel_format_to_rgba8, attached through a bind.
// Watches only the top-level ports; no package needed.
module tfr_port_checks
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [7:0]  m_tdata,
    input logic        m_tlast
);

    logic [3:0] run_cnt_reg;
    logic       seen_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_cnt_reg   <= 4'd0;
            seen_data_reg <= 1'b0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                run_cnt_reg <= m_tlast ? 4'd0 : run_cnt_reg + 4'd1;
            end
            if (s_tvalid && s_tready && s_tuser)
            begin
                seen_data_reg <= 1'b1;
            end
        end
    end

    // hold a stalled output beat
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("output beat changed while stalled");

    // no input beat expands to more than eight bytes
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready |-> run_cnt_reg <= 4'd7)
        else $error("output run longer than eight bytes");

    // palette writes alone never produce output
    assert property (@(posedge clk) disable iff (!rst_n)
        !seen_data_reg |-> !m_tvalid)
        else $error("output beat without any data beat");

    // bytes of one run leave without gaps
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready && !m_tlast |=> m_tvalid)
        else $error("gap inside an output run");

endmodule

bind texel_format_to_rgba8 tfr_port_checks u_tfr_checker (.*);

/* bench/tfr_bench_pkg.sv */
`timescale 1ns / 100ps
// Codes shared by the texel expander bench top and its checker.
// Depends on nothing; the block's own codes come from tfr_pkg.
package tfr_bench_pkg;

    // Input beat kind carried on s_tuser
    localparam logic ACT_PALWR = 1'b0;
    localparam logic ACT_DATA  = 1'b1;

    // format_mode encodings with no defined format
    localparam logic [2:0] MODE_SPARE6 = 3'd6;
    localparam logic [2:0] MODE_SPARE7 = 3'd7;

endpackage

/* bench/tfr_checker.sv */
`timescale 1ns / 100ps
// Checker for texel_format_to_rgba8: tracks palette, gather state and registers,
// expands each accepted input beat into its RGBA8 bytes and matches the output stream.
// Depends on tfr_pkg and tfr_bench_pkg.
module tfr_checker
    import tfr_pkg::*;
    import tfr_bench_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [2:0]  cfg_data,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [39:0] s_tdata,   // pal_index, pal_red, pal_green, pal_blue, data_byte
    input  logic        s_tuser,   // action
    input  logic        s_tlast,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [7:0]  m_tdata,   // out_byte
    input  logic        m_tlast,
    output int          pending,
    output int          fail_count
);

    typedef struct packed {
        logic [7:0] value;
        logic       last;
    } rgba_byte_t;

    rgba_byte_t  rgba_due[$];
    logic [23:0] pal_mem [256];
    logic [1:0]  gather_phase;
    logic [15:0] gather_held;
    logic [2:0]  fmt_mode;
    logic        alpha_on;
    int          errors = 0;

    assign fail_count = errors;

    task automatic push_byte(input logic [7:0] value);
        rgba_due.push_back('{value: value, last: 1'b0});
    endtask

    task automatic push_texel(input logic [23:0] rgb);
        push_byte(rgb[23:16]);
        push_byte(rgb[15:8]);
        push_byte(rgb[7:0]);
        push_byte(ALPHA_OPAQUE);
    endtask

    task automatic expand_texel_beat(input logic [39:0] beat, input logic act,
                                     input logic last);
        logic [7:0] data;
        logic [7:0] grey;
        int         depth;
        rgba_byte_t tail;
        data  = beat[39:32];
        depth = rgba_due.size();
        if (act == ACT_PALWR) begin
            pal_mem[beat[7:0]] = {beat[15:8], beat[23:16], beat[31:24]};
        end
        else begin
            case (fmt_mode)
                MODE_PAL4:
                begin
                    push_texel(pal_mem[data[7:4]]);
                    push_texel(pal_mem[data[3:0]]);
                end
                MODE_PAL8:   push_texel(pal_mem[data]);
                MODE_PASS16: push_byte(data);
                MODE_RGB:
                begin
                    if (alpha_on)
                        push_byte(data);
                    else if (gather_phase == 2'd0)
                    begin
                        gather_held  = {8'h00, data};
                        gather_phase = 2'd1;
                    end
                    else if (gather_phase == 2'd1)
                    begin
                        gather_held[15:8] = data;
                        gather_phase      = 2'd2;
                    end
                    else
                    begin
                        push_texel({gather_held[7:0], gather_held[15:8], data});
                        gather_phase = 2'd0;
                    end
                end
                MODE_GREY4:
                begin
                    grey = {data[7:4], 4'h0};
                    push_texel({3{grey}});
                    grey = {data[3:0], 4'h0};
                    push_texel({3{grey}});
                end
                MODE_GREY8: push_texel({3{data}});
                default: ;
            endcase
            // last data byte drops any partial RGB group
            if (last)
                gather_phase = 2'd0;
            // mark the final byte of this beat's run
            if (rgba_due.size() > depth)
            begin
                tail      = rgba_due.pop_back();
                tail.last = 1'b1;
                rgba_due.push_back(tail);
            end
        end
    endtask

    task automatic check_out_beat(input logic [7:0] value, input logic last);
        rgba_byte_t due;
        if (rgba_due.size() == 0)
        begin
            $display("%0t: unexpected out beat: byte %02h last %0b", $time, value, last);
            errors++;
        end
        else
        begin
            due = rgba_due.pop_front();
            if (value !== due.value)
            begin
                $display("%0t: out_byte mismatch: expected %02h, actual %02h",
                         $time, due.value, value);
                errors++;
            end
            if (last !== due.last)
            begin
                $display("%0t: last_byte mismatch: expected %0b, actual %0b (byte %02h)",
                         $time, due.last, last, value);
                errors++;
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rgba_due.delete();
            gather_phase = 2'd0;
            gather_held  = 16'h0000;
            fmt_mode     = MODE_PAL4;
            alpha_on     = 1'b0;
            pending     <= 0;
        end
        else
        begin
            // results never leave in the cycle their beat enters, so match first
            if (m_tvalid && m_tready)
                check_out_beat(m_tdata, m_tlast);
            if (cfg_we)
            begin
                if (cfg_index == REG_FORMAT_MODE)
                    fmt_mode = cfg_data;
                else
                    alpha_on = cfg_data[0];
            end
            if (s_tvalid && s_tready)
                expand_texel_beat(s_tdata, s_tuser, s_tlast);
            pending <= rgba_due.size();
        end
    end

endmodule

/* bench/tb_top.sv */
`timescale 1ns / 100ps
// Bench top for texel_format_to_rgba8: drives palette and texture beats with random
// gaps and output stalls, reprograms the format between phases, and reports the verdict.
// Depends on tfr_pkg, tfr_bench_pkg, tfr_checker and the block itself.
module tb_top;
    import tfr_pkg::*;
    import tfr_bench_pkg::*;

    localparam int LIMIT        = 500000;
    localparam int QUIET_CYCLES = 32;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_we;
    logic        cfg_index;
    logic [2:0]  cfg_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [39:0] s_tdata;   // pal_index, pal_red, pal_green, pal_blue, data_byte
    logic        s_tuser;   // action
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;   // out_byte
    logic        m_tlast;
    int          pending;
    int          fail_count;

    logic [2:0]  cur_mode;
    bit [255:0]  pal_written = '0;
    logic [7:0]  all_entries[$];
    logic [3:0]  low_entries[$];
    bit          steady = 1'b0;
    int          ready_left = 0;
    int          cycle_count = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    texel_format_to_rgba8 #(.PALETTE_ENTRIES(256)) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    tfr_checker i_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .s_tlast    (s_tlast),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .pending    (pending),
        .fail_count (fail_count)
    );

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // output side: ready stretches broken by stalls of random length
    always @(posedge clk)
    begin
        if (ready_left > 0)
            ready_left--;
        else if ($urandom_range(0, 3) == 0)
        begin
            m_tready  <= 1'b0;
            ready_left = idle_len();
        end
        else
        begin
            m_tready  <= 1'b1;
            ready_left = $urandom_range(1, 40);
        end
    end

    task automatic send_beat(input logic act, input logic [7:0] idx, input logic [7:0] red,
                             input logic [7:0] green, input logic [7:0] blue,
                             input logic [7:0] data, input logic last);
        int gap;
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= {data, blue, green, red, idx};
        s_tlast  <= last;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        gap = steady ? 0 : idle_len();
        // keep tvalid high when the next beat follows at once
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic send_palette(input logic [7:0] idx, input logic [7:0] red,
                                input logic [7:0] green, input logic [7:0] blue,
                                input logic last);
        send_beat(ACT_PALWR, idx, red, green, blue, 8'($urandom_range(0, 255)), last);
        if (!pal_written[idx])
        begin
            pal_written[idx] = 1'b1;
            all_entries.push_back(idx);
            if (idx < 8'd16)
                low_entries.push_back(idx[3:0]);
        end
    endtask

    // unused fields of a data beat carry noise
    task automatic send_texel(input logic [7:0] data, input logic last);
        send_beat(ACT_DATA, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                  8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), data, last);
    endtask

    task automatic wait_for_quiet();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
        // let beats with no result finish inside the block
        repeat (QUIET_CYCLES) @(posedge clk);
    endtask

    task automatic set_config(input logic [2:0] mode, input logic alpha);
        wait_for_quiet();
        cfg_we    <= 1'b1;
        cfg_index <= REG_FORMAT_MODE;
        cfg_data  <= mode;
        @(posedge clk);
        cfg_index <= REG_HAS_ALPHA;
        cfg_data  <= {2'b00, alpha};
        @(posedge clk);
        cfg_we   <= 1'b0;
        cur_mode  = mode;
    endtask

    // palette modes only look up entries already written
    function automatic logic [7:0] pick_texel_byte();
        logic [3:0] hi;
        logic [3:0] lo;
        case (cur_mode)
            MODE_PAL4:
            begin
                hi = low_entries[$urandom_range(0, low_entries.size() - 1)];
                lo = low_entries[$urandom_range(0, low_entries.size() - 1)];
                return {hi, lo};
            end
            MODE_PAL8: return all_entries[$urandom_range(0, all_entries.size() - 1)];
            default:   return 8'($urandom_range(0, 255));
        endcase
    endfunction

    initial
    begin
        while (cycle_count < LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        logic [2:0] mode;
        logic [7:0] idx;
        rst_n     <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_index <= REG_FORMAT_MODE;
        cfg_data  <= 3'd0;
        s_tvalid  <= 1'b0;
        s_tuser   <= ACT_PALWR;
        s_tdata   <= '0;
        s_tlast   <= 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // directed: palette extremes, tlast on a palette write is ignored
        set_config(MODE_PAL4, 1'b0);
        send_palette(8'd0, 8'h00, 8'h00, 8'h00, 1'b1);
        send_palette(8'd15, 8'hFF, 8'hFF, 8'hFF, 1'b0);
        send_palette(8'd255, 8'h80, 8'h0F, 8'hF0, 1'b0);
        send_texel(8'h0F, 1'b0);
        send_texel(8'hF0, 1'b0);
        send_texel(8'h00, 1'b1);

        set_config(MODE_PAL8, 1'b1);
        send_texel(8'hFF, 1'b0);
        send_texel(8'h00, 1'b0);
        send_texel(8'h0F, 1'b1);

        set_config(MODE_PASS16, 1'b0);
        send_texel(8'h00, 1'b0);
        send_texel(8'hFF, 1'b1);

        set_config(MODE_RGB, 1'b1);
        send_texel(8'h80, 1'b0);
        send_texel(8'h7F, 1'b0);

        // RGB gather: full group, group cut short by tlast, then a split group
        set_config(MODE_RGB, 1'b0);
        send_texel(8'h11, 1'b0);
        send_texel(8'h22, 1'b0);
        send_texel(8'h33, 1'b0);
        send_texel(8'hAA, 1'b0);
        send_texel(8'hBB, 1'b1);
        send_texel(8'hCC, 1'b0);
        send_texel(8'hDD, 1'b0);
        send_texel(8'hEE, 1'b0);
        send_texel(8'h44, 1'b0);

        // format change in the middle of a gather keeps the held byte
        set_config(MODE_GREY8, 1'b0);
        send_texel(8'hFF, 1'b0);
        set_config(MODE_RGB, 1'b0);
        send_texel(8'h55, 1'b0);
        send_texel(8'h66, 1'b1);

        set_config(MODE_GREY4, 1'b1);
        send_texel(8'hF0, 1'b0);
        send_texel(8'h0F, 1'b0);

        // undefined formats emit nothing
        set_config(MODE_SPARE6, 1'b0);
        send_texel(8'h99, 1'b0);
        set_config(MODE_SPARE7, 1'b1);
        send_texel(8'h77, 1'b1);

        // random phases
        for (int ph = 0; ph < 8; ph++)
        begin
            if ($urandom_range(0, 9) == 0)
                mode = 3'($urandom_range(6, 7));
            else
                mode = 3'($urandom_range(0, 5));
            set_config(mode, 1'($urandom_range(0, 1)));
            steady = ($urandom_range(0, 3) == 0);
            for (int n = 0; n < 11; n++)
            begin
                if ($urandom_range(0, 3) == 0)
                begin
                    if ($urandom_range(0, 1) == 0)
                        idx = 8'($urandom_range(0, 15));
                    else
                        idx = 8'($urandom_range(0, 255));
                    send_palette(idx, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                                 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
                end
                else
                    send_texel(pick_texel_byte(), $urandom_range(0, 9) == 0);
            end
        end

        steady = 1'b0;
        wait_for_quiet();
        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
